// File: sv/thop_pkg.sv
package thop_pkg;

    localparam int MaxSegmentLen = 65535;
    localparam int PosW = 17;
    localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_BAD_HLEN = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    localparam logic [7:0] KIND_END = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;
    localparam logic [7:0] KIND_SCALE = 8'd3;
    localparam logic [7:0] KIND_STAMP = 8'd8;
    localparam logic [7:0] LEN_SCALE = 8'd3;
    localparam logic [7:0] LEN_STAMP = 8'd10;

    // byte class decided by the front end
    typedef enum logic [2:0] {
        CL_HDR0,
        CL_HDR1,
        CL_HDR2,
        CL_OPT,
        CL_PAY
    } byte_class_t;

    typedef struct packed {
        byte_class_t    cls;
        logic [7:0]     data;
        logic           last;
        logic [PosW-1:0] pos;
    } class_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [5:0]  header_len;
        logic [7:0]  flag_bits;
        logic [15:0] peer_window;
        logic [31:0] stamp_value;
        logic [31:0] stamp_echo;
        logic [8:0]  scale_option;
        logic [15:0] payload_bytes;
    } result_t;

endpackage

// File: sv/thop_front.sv
module thop_front
    import thop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  in_data,
    input  logic        in_last,
    input  logic        take,
    output class_item_t item
);

    logic [PosW-1:0] pos_reg;
    logic [PosW-1:0] pos_next;
    logic [5:0]      hlen_reg;
    logic [5:0]      hlen_next;

    // classify by position; header length captured here at byte 12
    always_comb
    begin
        item.data = in_data;
        item.last = in_last;
        item.pos = pos_reg;
        if (pos_reg < PosW'(4))
            item.cls = CL_HDR0;
        else if (pos_reg < PosW'(12))
            item.cls = CL_HDR1;
        else if (pos_reg < PosW'(20))
            item.cls = CL_HDR2;
        else if (pos_reg < {{(PosW-6){1'b0}}, hlen_reg})
            item.cls = CL_OPT;
        else
            item.cls = CL_PAY;
    end

    always_comb
    begin
        pos_next = pos_reg;
        hlen_next = hlen_reg;
        if (in_valid && take)
        begin
            if (in_last)
            begin
                pos_next = '0;
                hlen_next = '0;
            end
            else
            begin
                if (pos_reg != PosMax)
                    pos_next = pos_reg + PosW'(1);
                if (pos_reg == PosW'(12))
                    hlen_next = {in_data[7:4], 2'b00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            hlen_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            hlen_reg <= hlen_next;
        end
    end

endmodule

// File: sv/thop_queue.sv
module thop_queue
    import thop_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  class_item_t wr_item,
    output logic        full,
    input  logic        rd_en,
    output logic        empty,
    output class_item_t rd_item
);

    class_item_t      slot_reg [2];
    logic             wp_reg;
    logic             rp_reg;
    logic [1:0]       cnt_reg;

    assign full = (cnt_reg == 2'd2);
    assign empty = (cnt_reg == 2'd0);
    assign rd_item = slot_reg[rp_reg];

    // two-entry item queue
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= ~wp_reg;
            if (rd_en)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_en) - 2'(rd_en);
        end
    end

endmodule

// File: sv/thop_back.sv
module thop_back
    import thop_pkg::*;
#(
    parameter int MAX_SEGMENT_LEN = MaxSegmentLen
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  class_item_t q_item,
    output logic        q_take,
    output logic        res_valid,
    output result_t     res,
    input  logic        res_stall
);

    typedef enum logic [1:0] {
        PH_KIND,
        PH_LEN,
        PH_BODY,
        PH_STOP
    } phase_t;

    logic [31:0] h0_reg, h0_next;
    logic [63:0] h1_reg, h1_next;
    logic [63:0] h2_reg, h2_next;
    phase_t      ph_reg, ph_next;
    logic [7:0]  kind_reg, kind_next;
    logic [7:0]  left_reg, left_next;
    logic        fits_reg, fits_next;
    logic [63:0] shadow_reg, shadow_next;
    logic [63:0] stamp_reg, stamp_next;
    logic [8:0]  scale_reg, scale_next;
    logic        rv_reg, rv_next;
    result_t     res_reg, res_next;

    logic        acc;
    logic [7:0]  b;
    logic [PosW:0] total;
    logic [5:0]  hl;
    logic [PosW:0] pay;

    assign q_take = q_valid && (!rv_reg || !res_stall);
    assign acc = q_take;
    assign b = q_item.data;
    assign res_valid = rv_reg;
    assign res = res_reg;

    always_comb
    begin
        h0_next = h0_reg;
        h1_next = h1_reg;
        h2_next = h2_reg;
        ph_next = ph_reg;
        kind_next = kind_reg;
        left_next = left_reg;
        fits_next = fits_reg;
        shadow_next = shadow_reg;
        stamp_next = stamp_reg;
        scale_next = scale_reg;
        rv_next = rv_reg && res_stall;
        res_next = res_reg;
        total = {1'b0, q_item.pos} + (PosW+1)'(1);
        hl = '0;
        pay = '0;
        if (acc)
        begin
            // field capture and option walk
            case (q_item.cls)
                CL_HDR0: h0_next = {h0_reg[23:0], b};
                CL_HDR1: h1_next = {h1_reg[55:0], b};
                CL_HDR2: h2_next = {h2_reg[55:0], b};
                CL_OPT:
                begin
                    case (ph_reg)
                        PH_KIND:
                        begin
                            if (b == KIND_END)
                                ph_next = PH_STOP;
                            else if (b != KIND_NOP)
                            begin
                                kind_next = b;
                                ph_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            if (b < 8'd2)
                                ph_next = PH_STOP;
                            else
                            begin
                                fits_next = (kind_reg == KIND_STAMP && b == LEN_STAMP)
                                    || (kind_reg == KIND_SCALE && b == LEN_SCALE);
                                shadow_next = '0;
                                left_next = b - 8'd2;
                                ph_next = (b == 8'd2) ? PH_KIND : PH_BODY;
                            end
                        end
                        PH_BODY:
                        begin
                            if (fits_reg && kind_reg == KIND_SCALE)
                            begin
                                scale_next = {1'b1, b};
                                fits_next = 1'b0;
                            end
                            shadow_next = {shadow_reg[55:0], b};
                            left_next = left_reg - 8'd1;
                            if (left_reg == 8'd1)
                            begin
                                if (fits_reg && kind_reg == KIND_STAMP)
                                    stamp_next = {shadow_reg[55:0], b};
                                fits_next = 1'b0;
                                ph_next = PH_KIND;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            // result on last byte, from the updated fields
            if (q_item.last)
            begin
                rv_next = 1'b1;
                res_next = '0;
                hl = {h2_next[63:60], 2'b00};
                if (total < (PosW+1)'(20))
                    res_next.status = ST_SHORT;
                else
                begin
                    res_next.source_port = h0_next[31:16];
                    res_next.dest_port = h0_next[15:0];
                    res_next.seq_num = h1_next[63:32];
                    res_next.ack_num = h1_next[31:0];
                    res_next.header_len = hl;
                    res_next.flag_bits = h2_next[55:48];
                    res_next.peer_window = h2_next[47:32];
                    if (hl < 6'd20 || {{(PosW-5){1'b0}}, hl} > total)
                        res_next.status = ST_BAD_HLEN;
                    else
                    begin
                        res_next.status = (total > (PosW+1)'(MAX_SEGMENT_LEN))
                            ? ST_TOO_LONG : ST_OK;
                        res_next.stamp_value = stamp_next[63:32];
                        res_next.stamp_echo = stamp_next[31:0];
                        res_next.scale_option = scale_next;
                        pay = total - {{(PosW-5){1'b0}}, hl};
                        res_next.payload_bytes = (pay > (PosW+1)'(16'hFFFF))
                            ? 16'hFFFF : pay[15:0];
                    end
                end
                h0_next = '0;
                h1_next = '0;
                h2_next = '0;
                ph_next = PH_KIND;
                kind_next = '0;
                left_next = '0;
                fits_next = 1'b0;
                shadow_next = '0;
                stamp_next = '0;
                scale_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg <= '0;
            h1_reg <= '0;
            h2_reg <= '0;
            ph_reg <= PH_KIND;
            kind_reg <= '0;
            left_reg <= '0;
            fits_reg <= 1'b0;
            shadow_reg <= '0;
            stamp_reg <= '0;
            scale_reg <= '0;
            rv_reg <= 1'b0;
        end
        else
        begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
            h2_reg <= h2_next;
            ph_reg <= ph_next;
            kind_reg <= kind_next;
            left_reg <= left_next;
            fits_reg <= fits_next;
            shadow_reg <= shadow_next;
            stamp_reg <= stamp_next;
            scale_reg <= scale_next;
            rv_reg <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// File: sv/tcp_header_option_parser.sv
// channel | signals                         | accepted when
// in      | in_valid in_stall data_byte ... | in_valid && !in_stall
// out     | out_valid out_stall status ...  | out_valid && !out_stall
//
// one byte per cycle sustained while in_stall is low; the front end tags each byte by position
// and pushes it into a two-entry queue, the back end walks each byte as it leaves the queue
// the last byte passes through a queue slot, then the back end result register, before out_valid
// rises; a stalled earlier result can hold it in the queue between the two
// in_stall rises only when the queue is full, i.e. after output stall
// rst_n clears positions, option state and valid flags asynchronously
module tcp_header_option_parser
    import thop_pkg::*;
#(
    parameter int MAX_SEGMENT_LEN = MaxSegmentLen
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] source_port,
    output logic [15:0] dest_port,
    output logic [31:0] seq_num,
    output logic [31:0] ack_num,
    output logic [5:0]  header_len,
    output logic [7:0]  flag_bits,
    output logic [15:0] peer_window,
    output logic [31:0] stamp_value,
    output logic [31:0] stamp_echo,
    output logic [8:0]  scale_option,
    output logic [15:0] payload_bytes
);

    class_item_t fe_item;
    class_item_t q_item;
    logic        q_full;
    logic        q_empty;
    logic        q_take;
    result_t     res;

    assign in_stall = q_full;

    thop_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_data(data_byte),
        .in_last(last_byte), .take(!q_full), .item(fe_item)
    );

    thop_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(in_valid && !q_full), .wr_item(fe_item),
        .full(q_full), .rd_en(q_take), .empty(q_empty), .rd_item(q_item)
    );

    thop_back #(.MAX_SEGMENT_LEN(MAX_SEGMENT_LEN)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(!q_empty), .q_item(q_item),
        .q_take(q_take), .res_valid(out_valid), .res(res),
        .res_stall(out_stall)
    );

    assign status = res.status;
    assign source_port = res.source_port;
    assign dest_port = res.dest_port;
    assign seq_num = res.seq_num;
    assign ack_num = res.ack_num;
    assign header_len = res.header_len;
    assign flag_bits = res.flag_bits;
    assign peer_window = res.peer_window;
    assign stamp_value = res.stamp_value;
    assign stamp_echo = res.stamp_echo;
    assign scale_option = res.scale_option;
    assign payload_bytes = res.payload_bytes;

    // queue never pops when empty
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> !q_take) else $error("pop from empty queue");

    // a stalled result stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");

    // short status clears the option fields
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_SHORT |-> scale_option == 9'd0 && payload_bytes == 16'd0)
        else $error("short segment fields not zero");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import thop_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [5:0]  header_len;
    logic [7:0]  flag_bits;
    logic [15:0] peer_window;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
    logic [8:0]  scale_option;
    logic [15:0] payload_bytes;

    tcp_header_option_parser dut (.*);

    // predictor state
    typedef enum logic [1:0] {WALK_KIND, WALK_LEN, WALK_BODY, WALK_STOP} walk_t;
    logic [16:0] seg_pos;
    logic [31:0] ports_word;
    logic [63:0] seq_ack_word;
    logic [63:0] off_win_word;
    walk_t       walk;
    logic [7:0]  held_kind;
    logic [7:0]  body_left;
    logic        capture_ok;
    logic [63:0] body_shift;
    logic [63:0] stamp_cap;
    logic [8:0]  scale_cap;

    result_t parsed_q[$];
    int      mismatches;
    int      results_seen;
    int      bytes_sent;
    int      segments_sent;
    logic    hold_off;
    logic    stall_bursts;

    always #5 clk = ~clk;

    function automatic void clear_parse();
        seg_pos = '0;
        ports_word = '0;
        seq_ack_word = '0;
        off_win_word = '0;
        walk = WALK_KIND;
        held_kind = '0;
        body_left = '0;
        capture_ok = 1'b0;
        body_shift = '0;
        stamp_cap = '0;
        scale_cap = '0;
    endfunction

    function automatic void walk_option(logic [7:0] b);
        case (walk)
            WALK_KIND:
            begin
                if (b == KIND_END)
                    walk = WALK_STOP;
                else if (b != KIND_NOP)
                begin
                    held_kind = b;
                    walk = WALK_LEN;
                end
            end
            WALK_LEN:
            begin
                if (b < 8'd2)
                    walk = WALK_STOP;
                else
                begin
                    capture_ok = (held_kind == KIND_STAMP && b == LEN_STAMP) ||
                                 (held_kind == KIND_SCALE && b == LEN_SCALE);
                    body_shift = '0;
                    body_left = b - 8'd2;
                    walk = (body_left != 0) ? WALK_BODY : WALK_KIND;
                end
            end
            WALK_BODY:
            begin
                if (capture_ok && held_kind == KIND_SCALE)
                begin
                    scale_cap = {1'b1, b};
                    capture_ok = 1'b0;
                end
                body_shift = {body_shift[55:0], b};
                body_left = body_left - 8'd1;
                if (body_left == 0)
                begin
                    if (capture_ok && held_kind == KIND_STAMP)
                        stamp_cap = body_shift;
                    capture_ok = 1'b0;
                    walk = WALK_KIND;
                end
            end
            default: ;
        endcase
    endfunction

    // advance the parser model by one byte, queue a result on the last one
    function automatic void parse_byte(logic [7:0] b, logic lst);
        int      total;
        int      hlen;
        int      plen;
        result_t r;
        hlen = off_win_word[63:60] * 4;
        if (seg_pos < 4)
            ports_word = {ports_word[23:0], b};
        else if (seg_pos < 12)
            seq_ack_word = {seq_ack_word[55:0], b};
        else if (seg_pos < 20)
            off_win_word = {off_win_word[55:0], b};
        else if (seg_pos < hlen)
            walk_option(b);
        if (!lst)
        begin
            if (seg_pos != PosMax)
                seg_pos = seg_pos + 1'b1;
            return;
        end
        total = int'(seg_pos) + 1;
        hlen = off_win_word[63:60] * 4;
        r = '0;
        if (total < 20)
            r.status = ST_SHORT;
        else
        begin
            r.source_port = ports_word[31:16];
            r.dest_port = ports_word[15:0];
            r.seq_num = seq_ack_word[63:32];
            r.ack_num = seq_ack_word[31:0];
            r.header_len = hlen[5:0];
            r.flag_bits = off_win_word[55:48];
            r.peer_window = off_win_word[47:32];
            if (hlen < 20 || hlen > total)
                r.status = ST_BAD_HLEN;
            else
            begin
                r.status = (total > MaxSegmentLen) ? ST_TOO_LONG : ST_OK;
                r.stamp_value = stamp_cap[63:32];
                r.stamp_echo = stamp_cap[31:0];
                r.scale_option = scale_cap;
                plen = total - hlen;
                r.payload_bytes = (plen > 65535) ? 16'hFFFF : plen[15:0];
            end
        end
        parsed_q.push_back(r);
        clear_parse();
    endfunction

    // send one byte, with random gaps between bursts
    int burst_left;
    task automatic send_byte(logic [7:0] b, logic lst);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 2) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, lst);
        bytes_sent++;
        if (lst)
            segments_sent++;
    endtask

    // build and send a segment; opts holds the option area bytes
    task automatic send_segment(int doff, int seg_len, logic [7:0] opts[$]);
        logic [7:0] b;
        for (int i = 0; i < seg_len; i++)
        begin
            b = 8'($urandom);
            if (i == 12)
                b = {doff[3:0], b[3:0]};
            else if (i >= 20 && i - 20 < opts.size())
                b = opts[i - 20];
            send_byte(b, i == seg_len - 1);
        end
    endtask

    // random option area of at least the given size, valid options mixed with stray bytes
    function automatic void make_options(int area, ref logic [7:0] opts[$]);
        int n;
        int k;
        opts = {};
        while (opts.size() < area)
        begin
            k = $urandom_range(0, 9);
            if (k < 3)
            begin
                opts.push_back(KIND_STAMP);
                opts.push_back(LEN_STAMP);
                repeat (8) opts.push_back(8'($urandom));
            end
            else if (k < 5)
            begin
                opts.push_back(KIND_SCALE);
                opts.push_back(LEN_SCALE);
                opts.push_back(8'($urandom));
            end
            else if (k < 7)
                opts.push_back(KIND_NOP);
            else if (k == 7)
            begin
                n = $urandom_range(2, 12);
                opts.push_back(8'($urandom_range(2, 255)));
                opts.push_back(8'(n));
                repeat (n - 2) opts.push_back(8'($urandom));
            end
            else if (k == 8)
                opts.push_back(8'($urandom));
            else
                opts.push_back(KIND_END);
        end
    endfunction

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic test_directed();
        logic [7:0] opts[$];
        // short segments, including a single byte
        send_segment(5, 1, opts);
        send_segment(5, 19, opts);
        // minimal header, no options, no payload
        send_segment(5, 20, opts);
        // data offset below five
        send_segment(0, 24, opts);
        send_segment(4, 40, opts);
        // header longer than the segment
        send_segment(15, 40, opts);
        // full option area: timestamp, scale, nop, end
        opts = '{KIND_NOP, KIND_NOP, KIND_STAMP, LEN_STAMP, 8'hFF, 8'h00, 8'hA5,
                 8'h5A, 8'h01, 8'h02, 8'h03, 8'h04, KIND_SCALE, LEN_SCALE, 8'hFF,
                 KIND_STAMP, LEN_STAMP, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
                 8'h77, 8'h88, KIND_END, KIND_SCALE, LEN_SCALE, 8'h07};
        send_segment(15, 70, opts);
        // length below two, wrong-length stamp, option running over the area
        opts = '{KIND_SCALE, LEN_SCALE, 8'h0E, 8'h40, 8'h01, KIND_SCALE, LEN_SCALE, 8'h09};
        send_segment(7, 30, opts);
        opts = '{KIND_STAMP, 8'd9, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                 KIND_STAMP, LEN_STAMP, 8'h01, 8'h02};
        send_segment(8, 32, opts);
        opts = '{8'd200, 8'd2, KIND_SCALE, LEN_SCALE, 8'h80, KIND_NOP, KIND_NOP, KIND_NOP};
        send_segment(7, 28, opts);
        wait_drained();
    endtask

    task automatic test_random();
        logic [7:0] opts[$];
        int doff;
        int len;
        int k;
        while (bytes_sent < 1400)
        begin
            k = $urandom_range(0, 9);
            doff = $urandom_range(5, 15);
            if (k == 0)
                doff = $urandom_range(0, 15);
            make_options(doff * 4 - 20, opts);
            if (k == 1 && opts.size() > 0)
                opts[$urandom_range(0, opts.size() - 1)] = 8'($urandom);
            len = doff * 4 + $urandom_range(0, 12);
            if (k == 2)
                len = $urandom_range(1, 30);
            send_segment(doff, len, opts);
        end
        wait_drained();
    endtask

    // sender keeps offering while the receiver holds off
    task automatic test_backpressure();
        logic [7:0] opts[$];
        hold_off = 1'b1;
        repeat (6) send_segment(5, 20, opts);
        hold_off = 1'b0;
        wait_drained();
    endtask

    // receiver stall pattern and a long hold-off window
    int hold_cycles;
    always @(posedge clk)
    begin
        if (hold_off)
            hold_cycles <= hold_cycles + 1;
        if (hold_off && hold_cycles < 60)
            out_stall <= 1'b1;
        else if (stall_bursts)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (($urandom_range(0, 199)) == 0)
            stall_bursts <= ~stall_bursts;
    end

    // compare each delivered result with the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, source_port, dest_port, seq_num, ack_num, header_len,
                    flag_bits, peer_window, stamp_value, stamp_echo,
                    scale_option, payload_bytes};
            results_seen++;
            if (parsed_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = parsed_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", want, got);
                end
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        stall_bursts = 1'b1;
        mismatches = 0;
        results_seen = 0;
        bytes_sent = 0;
        segments_sent = 0;
        burst_left = 0;
        clear_parse();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        repeat (10) @(posedge clk);
        if (parsed_q.size() != 0)
            mismatches += parsed_q.size();
        $display("covered %0d segments, %0d bytes, %0d results checked",
                 segments_sent, bytes_sent, results_seen);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
